// ----- hdl/bdlq_pkg.sv -----
`timescale 1ns / 1ps
package bdlq_pkg;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_FACTOR_DEF = 16;

    localparam logic [1:0] ADDR_FACTOR = 2'd0;
    localparam logic [1:0] ADDR_WIDTH  = 2'd1;
    localparam logic [1:0] ADDR_COLOR  = 2'd2;
    localparam logic [1:0] ADDR_INV    = 2'd3;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       frame_start;
    } t_pix;

    typedef struct packed {
        logic [4:0] level;
        logic [7:0] fg_red;
        logic [7:0] fg_green;
        logic [7:0] fg_blue;
        logic [7:0] bg_red;
        logic [7:0] bg_green;
        logic [7:0] bg_blue;
        logic       row_end;
    } t_cell;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture pixel, read line store
        logic accum;    // add and write back
        logic div_start;
        logic finish;   // form luma, load output
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emit;     // block completed by this pixel
        logic div_done;
        logic out_busy;
        logic cfg_busy; // blocks per row still being formed
    } t_sts;
endpackage

// ----- hdl/bdlq_ctrl.sv -----
`timescale 1ns / 1ps
module bdlq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bdlq_pkg::t_sts    i_sts,
    output bdlq_pkg::t_cmd    o_cmd
);
    import bdlq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;

    assign o_stall = (r_state != S_IDLE) || i_sts.cfg_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !i_sts.cfg_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                if (i_sts.emit) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: if (i_sts.div_done) n_state = S_WAIT;
            S_WAIT: if (!i_sts.out_busy) n_state = S_OUT;
            S_OUT: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_sts.cfg_busy) |-> !o_stall) else $error("stall in idle");
    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_cmd.load) else $error("double load");
    a_div_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == S_DIV)) else $error("div path");
endmodule

// ----- hdl/bdlq_dp.sv -----
`timescale 1ns / 1ps
module bdlq_dp #(
    parameter int MAX_WIDTH  = bdlq_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = bdlq_pkg::MAX_FACTOR_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdlq_pkg::t_cmd    i_cmd,
    output bdlq_pkg::t_sts    o_sts,
    input  bdlq_pkg::t_pix    i_pix,
    input  logic [4:0]        i_factor,
    input  logic [12:0]       i_width,
    input  logic              i_color,
    input  logic              i_inv,
    output logic              o_valid,
    input  logic              i_stall,
    output bdlq_pkg::t_cell   o_cell
);
    import bdlq_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int SW = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
    localparam int DW = 2 * FW + 1;           // holds 2*f*f
    localparam int NW = SW + 1;               // holds 2*sum+d

    // effective factor / width (clamped)
    logic [FW-1:0] f;
    logic [CW-1:0] w;
    always_comb begin
        if (i_factor == 5'd0) f = FW'(1);
        else if (32'(i_factor) > MAX_FACTOR) f = FW'(MAX_FACTOR);
        else f = FW'(i_factor);
        if (i_width == 13'd0) w = CW'(1);
        else if (32'(i_width) > MAX_WIDTH) w = CW'(MAX_WIDTH);
        else w = CW'(i_width);
    end

    // counters
    logic [CW-1:0] r_scol, r_bcol, r_full;
    logic [FW-1:0] r_rib, r_cib;
    logic [CW-1:0] scol, bcol;
    logic [FW-1:0] rib, cib;
    logic [FW-1:0] fm1;
    logic [CW-1:0] wm1;
    assign fm1 = f - FW'(1);
    assign wm1 = w - CW'(1);

    always_comb begin
        scol = r_scol; bcol = r_bcol; rib = r_rib; cib = r_cib;
        if (i_pix.frame_start) begin
            scol = '0; bcol = '0; rib = '0; cib = '0;
        end
    end

    // full = w / f, formed by a short restoring divider whenever f or w changes
    logic [FW+CW-1:0] r_key;
    logic             r_key_ok, r_fbusy;
    logic [CW-1:0]    r_fnum, r_frem;
    logic [3:0]       r_fcnt;
    logic             full_stale;
    logic [CW:0]      ft;
    assign full_stale = !r_key_ok || (r_key != {f, w});
    assign ft = {r_frem, r_fnum[CW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_ok <= 1'b0;
            r_fbusy  <= 1'b0;
        end else if (r_fbusy) begin
            if (r_fcnt == 4'd1) r_fbusy <= 1'b0;
        end else if (full_stale) begin
            r_key_ok <= 1'b1;
            r_fbusy  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_fbusy && full_stale) begin
            r_key  <= {f, w};
            r_fnum <= w;
            r_frem <= '0;
            r_full <= '0;
            r_fcnt <= 4'(CW);
        end else if (r_fbusy) begin
            r_fnum <= {r_fnum[CW-2:0], 1'b0};
            r_fcnt <= r_fcnt - 4'd1;
            if (ft >= (CW+1)'(f)) begin
                r_frem <= CW'(ft - (CW+1)'(f));
                r_full <= {r_full[CW-2:0], 1'b1};
            end else begin
                r_frem <= CW'(ft);
                r_full <= {r_full[CW-2:0], 1'b0};
            end
        end
    end

    // pixel lies in a full block: bcol < full, scol < full*f and bcol < MAX_WIDTH
    logic [CW+FW:0] full_end;
    assign full_end = (CW+FW+1)'(r_full) * (CW+FW+1)'(f);
    logic in_full, last_blk;
    assign in_full  = (bcol < r_full) && ((CW+FW+1)'(scol) < full_end)
                      && (bcol < CW'(MAX_WIDTH));
    assign last_blk = (bcol + CW'(1)) == r_full;

    // pixel stage
    t_pix          r_px;
    logic          r_hit, r_first, r_emit, r_rend;
    logic [AW-1:0] r_addr;

    // line store
    logic [3*SW-1:0] mem [MAX_WIDTH];
    logic [3*SW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_rd <= mem[AW'(bcol)];
    end

    logic [SW-1:0] sr, sg, sb;
    always_comb begin
        if (r_first) begin
            sr = SW'(r_px.red_in); sg = SW'(r_px.green_in); sb = SW'(r_px.blue_in);
        end else begin
            sr = r_rd[3*SW-1:2*SW] + SW'(r_px.red_in);
            sg = r_rd[2*SW-1:SW]   + SW'(r_px.green_in);
            sb = r_rd[SW-1:0]      + SW'(r_px.blue_in);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && r_hit) mem[r_addr] <= {sr, sg, sb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol <= '0; r_bcol <= '0; r_rib <= '0; r_cib <= '0;
            r_hit <= 1'b0; r_emit <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit  <= in_full;
            r_emit <= in_full && (rib >= fm1) && (cib >= fm1);
            if (scol >= wm1) begin
                r_scol <= '0; r_cib <= '0; r_bcol <= '0;
                r_rib  <= (rib >= fm1) ? '0 : rib + FW'(1);
            end else begin
                r_scol <= scol + CW'(1);
                if (cib >= fm1) begin
                    r_cib <= '0;
                    r_bcol <= (bcol < CW'(MAX_WIDTH)) ? bcol + CW'(1) : bcol;
                end else begin
                    r_cib <= cib + FW'(1); r_bcol <= bcol;
                end
                r_rib <= rib;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px    <= i_pix;
            r_first <= (rib == '0) && (cib == '0);
            r_addr  <= AW'(bcol);
            r_rend  <= last_blk;
        end
    end

    // shared restoring divider, one quotient bit per cycle, three channels
    localparam int QW = 9;
    logic [NW-1:0] r_num [3];
    logic [NW-1:0] r_rem [3];
    logic [QW-1:0] r_q [3];
    logic [DW-1:0] r_den;
    logic [4:0]    r_dcnt;
    logic          r_dbusy;
    localparam int BITS = NW;
    logic [DW-1:0] dd;
    assign dd = DW'(f) * DW'(f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= 5'(BITS);
        end else if (r_dbusy) begin
            if (r_dcnt == 5'd1) r_dbusy <= 1'b0;
            r_dcnt <= r_dcnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_den    <= DW'({dd, 1'b0});
            r_num[0] <= {sr, 1'b0} + NW'(dd);
            r_num[1] <= {sg, 1'b0} + NW'(dd);
            r_num[2] <= {sb, 1'b0} + NW'(dd);
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= '0; r_q[k] <= '0;
            end
        end else if (r_dbusy) begin
            for (int k = 0; k < 3; k++) begin
                logic [NW:0] t;
                t = {r_rem[k], r_num[k][NW-1]};
                r_num[k] <= {r_num[k][NW-2:0], 1'b0};
                if (t >= (NW+1)'(r_den)) begin
                    r_rem[k] <= NW'(t - (NW+1)'(r_den));
                    r_q[k]   <= {r_q[k][QW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= NW'(t);
                    r_q[k]   <= {r_q[k][QW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_sts.emit     = r_emit;
    assign o_sts.div_done = r_dbusy && (r_dcnt == 5'd1);
    assign o_sts.out_busy = o_valid && i_stall;
    assign o_sts.cfg_busy = r_fbusy || full_stale;

    // luma and colors
    logic [7:0] ar, ag, ab;
    assign ar = r_q[0][8] ? 8'd255 : r_q[0][7:0];
    assign ag = r_q[1][8] ? 8'd255 : r_q[1][7:0];
    assign ab = r_q[2][8] ? 8'd255 : r_q[2][7:0];
    logic [19:0] luma;
    assign luma = 20'd306 * 20'(ar) + 20'd601 * 20'(ag) + 20'd116 * 20'(ab);
    logic [9:0] gray;
    assign gray = luma[19:10];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_cell.level   <= 5'((gray + 10'd8) >> 4);
            o_cell.row_end <= r_rend;
            if (!i_color) begin
                {o_cell.fg_red, o_cell.fg_green, o_cell.fg_blue} <= '0;
                {o_cell.bg_red, o_cell.bg_green, o_cell.bg_blue} <= '1;
            end else if (i_inv) begin
                {o_cell.fg_red, o_cell.fg_green, o_cell.fg_blue} <= '1;
                {o_cell.bg_red, o_cell.bg_green, o_cell.bg_blue} <= {ar, ag, ab};
            end else begin
                {o_cell.fg_red, o_cell.fg_green, o_cell.fg_blue} <= {ar, ag, ab};
                {o_cell.bg_red, o_cell.bg_green, o_cell.bg_blue} <= '1;
            end
        end
    end

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !(o_valid && i_stall)) else $error("overwrite of held cell");
    a_emit_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> r_hit) else $error("emit without block");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_dbusy) else $error("divider restarted");
endmodule

// ----- hdl/box_downsample_luma_quantizer_core.sv -----
`timescale 1ns / 1ps
// Box downsampler with luma quantizer.
// Input channel (i_valid/o_stall, i_pix): RGB pixels in raster order,
// frame_start on the first pixel of a frame clears the counters.
// Output channel (o_valid/i_stall, o_cell): one cell per completed
// factor x factor block with level, foreground/background color, row_end.
// Configuration over APB: 0 factor, 1 width, 2 color mode, 3 inverse mode,
// at byte addresses 0,4,8,12; write only while idle.
// A pixel that finishes no block passes a load step and a line-store
// read-modify-write step. A block-completing pixel adds the bit-serial
// divider (one quotient bit a cycle), one slot check and one output step.
// After reset or a change of factor or width the input stalls while
// the blocks per row (width / factor) are formed.
// The output register holds a cell while i_stall is high; the next pixel
// is still taken, and a following cell waits until the register is free.
// Reset (synchronous, i_rst_n low) clears counters and handshakes and
// loads register defaults; the line store is not cleared.
module box_downsample_luma_quantizer_core #(
    parameter int MAX_WIDTH  = bdlq_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = bdlq_pkg::MAX_FACTOR_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bdlq_pkg::t_pix    i_pix,
    output logic              o_valid,
    input  logic              i_stall,
    output bdlq_pkg::t_cell   o_cell,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import bdlq_pkg::*;

    logic [4:0]  r_factor;
    logic [12:0] r_width;
    logic        r_color, r_inv;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= 5'd1;
            r_width  <= 13'd4096;
            r_color  <= 1'b0;
            r_inv    <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                ADDR_FACTOR: r_factor <= pwdata[4:0];
                ADDR_WIDTH:  r_width  <= pwdata[12:0];
                ADDR_COLOR:  r_color  <= pwdata[0];
                ADDR_INV:    r_inv    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ADDR_FACTOR: prdata = {27'd0, r_factor};
            ADDR_WIDTH:  prdata = {19'd0, r_width};
            ADDR_COLOR:  prdata = {31'd0, r_color};
            ADDR_INV:    prdata = {31'd0, r_inv};
            default:     prdata = '0;
        endcase
    end

    t_cmd cmd;
    t_sts sts;

    bdlq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_sts(sts), .o_cmd(cmd)
    );

    bdlq_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_FACTOR(MAX_FACTOR)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts), .i_pix,
        .i_factor(r_factor), .i_width(r_width), .i_color(r_color), .i_inv(r_inv),
        .o_valid, .i_stall, .o_cell
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("cell dropped");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && i_valid) |=> i_valid) else $error("valid withdrawn");
    a_ready: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule
